// ===== rtl/mqrb_pkg.sv =====
// -----------------------------------------------------------------------------
// Multi-queue message ring buffer package
// Shared request and response types, operation and status codes, and defaults.
// -----------------------------------------------------------------------------
`default_nettype none

package mqrb_pkg;

	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_BYTES_DEF = 1024;
	localparam int MAX_MSG_LEN_DEF = 64;

	localparam int OP_W   = 2;
	localparam int QSEL_W = 3;
	localparam int LEN_W  = 7;
	localparam int BYTE_W = 8;

	// Enqueue byte counter saturates here.
	localparam logic [LEN_W-1:0] OFFSET_SAT = '1;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ      = 2'd0,
		OP_DEQ      = 2'd1,
		OP_ROLLBACK = 2'd2,
		OP_RESET    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_PTR,
		CS_DEQ
	} ctrl_state_t;

	typedef struct packed {
		op_t               op;
		logic [QSEL_W-1:0] queue_sel;
		logic [LEN_W-1:0]  msg_len;
		logic [BYTE_W-1:0] data_in;
		logic              last_in;
	} req_item_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] data_out;
		logic              data_valid;
		logic              last_out;
	} rsp_item_t;

	// Occupancy of the response queue as seen by the sequencer.
	typedef struct packed {
		logic [1:0] count;
		logic       pop;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/multi_queue_message_ring_buffer_top.sv =====
// -----------------------------------------------------------------------------
// Multi-queue message ring buffer
// Byte ring buffers for several queues, with message enqueue and dequeue.
// -----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid / req_ready with the payload in req; results
// leave on rsp_valid / rsp_ready with the payload in rsp. Each request is
// one enqueue byte, one dequeue of a whole message, a tail rollback or a
// queue reset. An enqueue byte gives a result only on its last byte (or for a
// zero-length message); a dequeue of N bytes gives N results, the last marked.
// Requests are handled one at a time. Every request first reads its queue's
// pointers from the pointer memory; an enqueue byte, rollback or reset is then
// done in that pointer step. A dequeue of N bytes then reads one byte per cycle,
// while the response queue has room, through the single read port of the byte
// store. After the last byte is read, a new request waits for a free response
// slot besides the last byte still being read.
// Status results and dequeued bytes pass through the response queue; with a
// ready receiver the dequeued bytes follow one per cycle.
// A two-entry response queue sits in front of rsp; when the receiver stalls
// the dequeue stream pauses and no new request is taken until there is room.
// Reset clears the state machine, the enqueue progress and the pointers of
// all queues at once (valid bits on the pointer memory); no clearing pass is
// run and the byte store itself is not initialized.
// -----------------------------------------------------------------------------
`default_nettype none

module multi_queue_message_ring_buffer_top #(
	parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_BYTES = mqrb_pkg::QUEUE_BYTES_DEF,
	parameter int MAX_MSG_LEN = mqrb_pkg::MAX_MSG_LEN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire mqrb_pkg::req_item_t  req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output mqrb_pkg::rsp_item_t       rsp
);

	localparam int PW = $clog2(QUEUE_BYTES);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

	mqrb_pkg::fifo_stat_t        fifo_stat;
	mqrb_pkg::rsp_item_t         push_item;
	logic                        push_valid;
	logic                        ptr_rd_en, ptr_wr_en;
	logic [QW-1:0]               ptr_rd_addr, ptr_wr_addr;
	logic [PW-1:0]               ptr_rd_head, ptr_rd_tail, ptr_wr_head, ptr_wr_tail;
	logic                        byte_rd_en, byte_wr_en;
	logic [QW+PW-1:0]            byte_rd_addr, byte_wr_addr;
	logic [mqrb_pkg::BYTE_W-1:0] byte_rd_data, byte_wr_data;

	// The sequencer owns all decisions; memories and the response queue just store.
	mqrb_ctrl #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_BYTES (QUEUE_BYTES),
		.MAX_MSG_LEN (MAX_MSG_LEN)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.fifo         (fifo_stat),
		.push_valid   (push_valid),
		.push_item    (push_item),
		.ptr_rd_en    (ptr_rd_en),
		.ptr_rd_addr  (ptr_rd_addr),
		.ptr_rd_head  (ptr_rd_head),
		.ptr_rd_tail  (ptr_rd_tail),
		.ptr_wr_en    (ptr_wr_en),
		.ptr_wr_addr  (ptr_wr_addr),
		.ptr_wr_head  (ptr_wr_head),
		.ptr_wr_tail  (ptr_wr_tail),
		.byte_rd_en   (byte_rd_en),
		.byte_rd_addr (byte_rd_addr),
		.byte_rd_data (byte_rd_data),
		.byte_wr_en   (byte_wr_en),
		.byte_wr_addr (byte_wr_addr),
		.byte_wr_data (byte_wr_data)
	);

	// Head and tail of every queue.
	mqrb_ptr_mem #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_BYTES (QUEUE_BYTES)
	) u_ptr_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ptr_rd_en),
		.rd_addr (ptr_rd_addr),
		.rd_head (ptr_rd_head),
		.rd_tail (ptr_rd_tail),
		.wr_en   (ptr_wr_en),
		.wr_addr (ptr_wr_addr),
		.wr_head (ptr_wr_head),
		.wr_tail (ptr_wr_tail)
	);

	// Message bytes, addressed by queue and position within the queue.
	mqrb_byte_mem #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_BYTES (QUEUE_BYTES)
	) u_byte_mem (
		.clk     (clk),
		.rd_en   (byte_rd_en),
		.rd_addr (byte_rd_addr),
		.rd_data (byte_rd_data),
		.wr_en   (byte_wr_en),
		.wr_addr (byte_wr_addr),
		.wr_data (byte_wr_data)
	);

	// Results wait here while the receiver stalls.
	mqrb_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.stat       (fifo_stat),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	// The sequencer must never push into a full response queue.
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> (fifo_stat.count != 2'd2))
		else $error("result pushed into a full response queue");

	// Pointer reads and writes never overlap, so no forwarding is needed.
	a_ptr_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ptr_rd_en && ptr_wr_en))
		else $error("pointer memory read and write in the same cycle");

	// Byte store reads happen only while dequeuing, never alongside an enqueue write.
	a_byte_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(byte_rd_en && byte_wr_en))
		else $error("byte store read and write in the same cycle");

	// Every issued byte read turns into a result in the following cycle.
	a_read_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		byte_rd_en |=> (push_valid && push_item.data_valid))
		else $error("dequeued byte was not pushed to the response queue");

endmodule

`default_nettype wire

// ===== rtl/mqrb_ptr_mem.sv =====
// -----------------------------------------------------------------------------
// Pointer memory
// Head and tail of every queue, one synchronous read and one write port.
// -----------------------------------------------------------------------------
`default_nettype none

module mqrb_ptr_mem #(
	parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_BYTES = mqrb_pkg::QUEUE_BYTES_DEF,
	localparam int PW = $clog2(QUEUE_BYTES),
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [QW-1:0]         rd_addr,
	output logic      [PW-1:0]         rd_head,
	output logic      [PW-1:0]         rd_tail,
	input  wire logic                  wr_en,
	input  wire logic [QW-1:0]         wr_addr,
	input  wire logic [PW-1:0]         wr_head,
	input  wire logic [PW-1:0]         wr_tail
);

	logic [2*PW-1:0] mem [NUM_QUEUES];
	logic            valid_q [NUM_QUEUES];
	logic [PW-1:0]   head_q;
	logic [PW-1:0]   tail_q;

	// An entry never written since reset reads as zero pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_head, wr_tail};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (valid_q[rd_addr]) begin
				{head_q, tail_q} <= mem[rd_addr];
			end else begin
				head_q <= '0;
				tail_q <= '0;
			end
		end
	end

	assign rd_head = head_q;
	assign rd_tail = tail_q;

endmodule

`default_nettype wire

// ===== rtl/mqrb_byte_mem.sv =====
// -----------------------------------------------------------------------------
// Byte store
// Message bytes of all queues, one synchronous read and one write port.
// -----------------------------------------------------------------------------
`default_nettype none

module mqrb_byte_mem #(
	parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_BYTES = mqrb_pkg::QUEUE_BYTES_DEF,
	localparam int PW = $clog2(QUEUE_BYTES),
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
	localparam int AW = QW + PW
) (
	input  wire logic                          clk,
	input  wire logic                          rd_en,
	input  wire logic [AW-1:0]                 rd_addr,
	output logic      [mqrb_pkg::BYTE_W-1:0]   rd_data,
	input  wire logic                          wr_en,
	input  wire logic [AW-1:0]                 wr_addr,
	input  wire logic [mqrb_pkg::BYTE_W-1:0]   wr_data
);

	localparam int DEPTH = NUM_QUEUES * (2 ** PW);

	logic [mqrb_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [mqrb_pkg::BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/mqrb_out_fifo.sv =====
// -----------------------------------------------------------------------------
// Response queue
// Two-entry queue that decouples result production from the receiver.
// -----------------------------------------------------------------------------
`default_nettype none

module mqrb_out_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push_valid,
	input  wire mqrb_pkg::rsp_item_t    push_item,
	output mqrb_pkg::fifo_stat_t        stat,
	output logic                        rsp_valid,
	input  wire logic                   rsp_ready,
	output mqrb_pkg::rsp_item_t         rsp
);

	mqrb_pkg::rsp_item_t ent_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                pop;

	assign rsp_valid  = (count_q != 2'd0);
	assign rsp        = ent_q[rd_ptr_q];
	assign pop        = rsp_valid && rsp_ready;
	assign stat.count = count_q;
	assign stat.pop   = pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push_valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mqrb_ctrl.sv =====
// -----------------------------------------------------------------------------
// Sequencer
// Reads a queue's pointers, decides the operation, writes bytes and pointers
// back, and streams dequeued bytes into the response queue.
// -----------------------------------------------------------------------------
`default_nettype none

module mqrb_ctrl #(
	parameter int NUM_QUEUES  = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_BYTES = mqrb_pkg::QUEUE_BYTES_DEF,
	parameter int MAX_MSG_LEN = mqrb_pkg::MAX_MSG_LEN_DEF,
	localparam int PW = $clog2(QUEUE_BYTES),
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire mqrb_pkg::req_item_t          req,
	input  wire mqrb_pkg::fifo_stat_t         fifo,
	output logic                              push_valid,
	output mqrb_pkg::rsp_item_t               push_item,
	output logic                              ptr_rd_en,
	output logic      [QW-1:0]                ptr_rd_addr,
	input  wire logic [PW-1:0]                ptr_rd_head,
	input  wire logic [PW-1:0]                ptr_rd_tail,
	output logic                              ptr_wr_en,
	output logic      [QW-1:0]                ptr_wr_addr,
	output logic      [PW-1:0]                ptr_wr_head,
	output logic      [PW-1:0]                ptr_wr_tail,
	output logic                              byte_rd_en,
	output logic      [QW+PW-1:0]             byte_rd_addr,
	input  wire logic [mqrb_pkg::BYTE_W-1:0]  byte_rd_data,
	output logic                              byte_wr_en,
	output logic      [QW+PW-1:0]             byte_wr_addr,
	output logic      [mqrb_pkg::BYTE_W-1:0]  byte_wr_data
);

	localparam int LW    = mqrb_pkg::LEN_W;
	localparam int CW    = ((PW > LW) ? PW : LW) + 2;
	localparam logic [CW-1:0] QB_C  = CW'(QUEUE_BYTES);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_MSG_LEN);

	// Values here stay below twice the queue size, so one subtract wraps them.
	function automatic logic [CW-1:0] wrap_once(input logic [CW-1:0] v);
		return (v >= QB_C) ? (v - QB_C) : v;
	endfunction

	mqrb_pkg::ctrl_state_t state_q, state_d;
	mqrb_pkg::req_item_t   item_q;
	logic                  in_range_q;
	logic [LW-1:0]         enq_offset_q, enq_off_d;
	logic                  enq_accepted_q, enq_acc_d;
	logic                  enq_upd;
	logic [LW-1:0]         deq_idx_q;
	logic                  rd_pend_q;
	logic                  rd_last_q;

	logic [QW-1:0] qidx_q;
	logic          req_in_range;
	logic [CW-1:0] h_ext, t_ext, len_ext, off_ext, idx_ext;
	logic [CW-1:0] free_sp, used_sp;
	logic          first, len_zero, acc_now, wr_byte, deq_bad;
	logic [LW-1:0] off_next;
	logic [CW-1:0] off_next_ext, adv, adv_a, back;
	logic [CW-1:0] enq_pos, tail_enq, tail_rb, head_deq, deq_pos;
	logic [LW-1:0] deq_idx_next;
	logic          deq_last;
	logic [2:0]    occ;
	logic          room, issue_ok;
	logic          stat_push;
	mqrb_pkg::status_t stat_code;

	assign qidx_q       = QW'(item_q.queue_sel);
	assign req_in_range = (int'(req.queue_sel) < NUM_QUEUES);

	// Pointer arithmetic on the pointers read for the current request.
	assign h_ext   = CW'(ptr_rd_head);
	assign t_ext   = CW'(ptr_rd_tail);
	assign len_ext = CW'(item_q.msg_len);
	assign off_ext = CW'(enq_offset_q);
	assign idx_ext = CW'(deq_idx_q);
	assign free_sp = wrap_once(h_ext + QB_C - t_ext - CW'(1));
	assign used_sp = wrap_once(t_ext + QB_C - h_ext);

	assign first    = (enq_offset_q == '0);
	assign len_zero = (item_q.msg_len == '0);
	assign acc_now  = first ? ((len_ext <= MAX_C) && (len_ext <= free_sp)) : enq_accepted_q;
	assign wr_byte  = acc_now && (off_ext < len_ext) && (off_ext < free_sp);
	assign enq_pos  = wrap_once(t_ext + off_ext);
	assign off_next = (enq_offset_q != mqrb_pkg::OFFSET_SAT) ? enq_offset_q + LW'(1)
		: enq_offset_q;
	assign off_next_ext = CW'(off_next);
	assign adv_a    = (off_next_ext < len_ext) ? off_next_ext : len_ext;
	assign adv      = (adv_a < free_sp) ? adv_a : free_sp;
	assign tail_enq = wrap_once(t_ext + adv);

	assign deq_bad  = (len_ext > MAX_C) || (len_ext > used_sp);
	assign back     = (len_ext >= QB_C) ? (len_ext - QB_C) : len_ext;
	assign tail_rb  = wrap_once(t_ext + QB_C - back);
	assign head_deq = wrap_once(h_ext + len_ext);
	assign deq_pos  = wrap_once(h_ext + idx_ext);
	assign deq_idx_next = deq_idx_q + LW'(1);
	assign deq_last     = (deq_idx_next == item_q.msg_len);

	// Response queue slots already spoken for, counting a read in flight.
	assign occ      = {1'b0, fifo.count} + {2'b00, rd_pend_q};
	assign room     = (occ < 3'd2);
	assign issue_ok = (occ <= (3'd1 + {2'b00, fifo.pop}));

	assign byte_wr_addr = {qidx_q, enq_pos[PW-1:0]};
	assign byte_wr_data = item_q.data_in;
	assign byte_rd_addr = {qidx_q, deq_pos[PW-1:0]};
	assign ptr_rd_addr  = QW'(req.queue_sel);
	assign ptr_wr_addr  = qidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqrb_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		ptr_rd_en   = 1'b0;
		ptr_wr_en   = 1'b0;
		ptr_wr_head = ptr_rd_head;
		ptr_wr_tail = ptr_rd_tail;
		byte_rd_en  = 1'b0;
		byte_wr_en  = 1'b0;
		stat_push   = 1'b0;
		stat_code   = mqrb_pkg::ST_OK;
		enq_upd     = 1'b0;
		enq_off_d   = enq_offset_q;
		enq_acc_d   = enq_accepted_q;
		unique case (state_q)
			mqrb_pkg::CS_IDLE: begin
				req_ready = room;
				if (req_valid && room) begin
					ptr_rd_en = req_in_range;
					state_d   = mqrb_pkg::CS_PTR;
				end
			end
			mqrb_pkg::CS_PTR: begin
				state_d = mqrb_pkg::CS_IDLE;
				if (in_range_q) begin
					unique case (item_q.op)
						mqrb_pkg::OP_ENQ: begin
							if (first && len_zero) begin
								stat_push = 1'b1;
							end else begin
								byte_wr_en = wr_byte;
								enq_upd    = 1'b1;
								if (item_q.last_in) begin
									stat_push = 1'b1;
									enq_off_d = '0;
									enq_acc_d = 1'b0;
									if (acc_now) begin
										ptr_wr_en   = 1'b1;
										ptr_wr_tail = tail_enq[PW-1:0];
									end else begin
										stat_code = mqrb_pkg::ST_OVERFLOW;
									end
								end else begin
									enq_off_d = off_next;
									enq_acc_d = acc_now;
								end
							end
						end
						mqrb_pkg::OP_DEQ: begin
							if (len_zero) begin
								stat_push = 1'b1;
							end else if (deq_bad) begin
								ptr_wr_en   = 1'b1;
								ptr_wr_head = '0;
								ptr_wr_tail = '0;
								stat_push   = 1'b1;
								stat_code   = mqrb_pkg::ST_UNDERFLOW;
							end else begin
								state_d = mqrb_pkg::CS_DEQ;
							end
						end
						mqrb_pkg::OP_ROLLBACK: begin
							ptr_wr_en   = 1'b1;
							ptr_wr_tail = tail_rb[PW-1:0];
							stat_push   = 1'b1;
						end
						mqrb_pkg::OP_RESET: begin
							ptr_wr_en   = 1'b1;
							ptr_wr_head = '0;
							ptr_wr_tail = '0;
							stat_push   = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			mqrb_pkg::CS_DEQ: begin
				if (issue_ok) begin
					byte_rd_en = 1'b1;
					if (deq_last) begin
						ptr_wr_en   = 1'b1;
						ptr_wr_head = head_deq[PW-1:0];
						state_d     = mqrb_pkg::CS_IDLE;
					end
				end
			end
			default: begin
				state_d = mqrb_pkg::CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q     <= 1'b0;
			enq_offset_q   <= '0;
			enq_accepted_q <= 1'b0;
			deq_idx_q      <= '0;
			rd_pend_q      <= 1'b0;
			rd_last_q      <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				in_range_q <= req_in_range;
			end
			if (enq_upd) begin
				enq_offset_q   <= enq_off_d;
				enq_accepted_q <= enq_acc_d;
			end
			if (state_q == mqrb_pkg::CS_PTR) begin
				deq_idx_q <= '0;
			end else if (byte_rd_en) begin
				deq_idx_q <= deq_idx_next;
			end
			rd_pend_q <= byte_rd_en;
			if (byte_rd_en) begin
				rd_last_q <= deq_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
	end

	// A byte read lands in the cycle after it is issued and never meets a status push.
	always_comb begin
		push_valid = stat_push || rd_pend_q;
		if (rd_pend_q) begin
			push_item = '{status: mqrb_pkg::ST_OK, data_out: byte_rd_data,
				data_valid: 1'b1, last_out: rd_last_q};
		end else begin
			push_item = '{status: stat_code, data_out: '0,
				data_valid: 1'b0, last_out: 1'b1};
		end
	end

endmodule

`default_nettype wire
